/* hdl/hsu_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsu_pkg
// Shared types and constants of the handheld sound unit: operation and result
// codes, register offsets, controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package hsu_pkg;

   localparam logic [2:0] OP_WRITE16 = 3'd0;
   localparam logic [2:0] OP_WRITE8  = 3'd1;
   localparam logic [2:0] OP_READ16  = 3'd2;
   localparam logic [2:0] OP_TIMER   = 3'd3;
   localparam logic [2:0] OP_TICK    = 3'd4;

   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_READ   = 2'd1;
   localparam logic [1:0] KIND_DMA    = 2'd2;

   localparam logic [9:0] REG_SQ1_CTL  = 10'h062;
   localparam logic [9:0] REG_SQ1_FREQ = 10'h064;
   localparam logic [9:0] REG_SQ2_CTL  = 10'h068;
   localparam logic [9:0] REG_SQ2_FREQ = 10'h06C;
   localparam logic [9:0] REG_ROUTE    = 10'h080;
   localparam logic [9:0] REG_MIX      = 10'h082;
   localparam logic [9:0] REG_MASTER   = 10'h084;
   localparam logic [9:0] REG_BIAS     = 10'h088;
   localparam logic [9:0] REG_SAMPLE_A = 10'h0A0;
   localparam logic [9:0] REG_SAMPLE_B = 10'h0A4;
   localparam logic [9:0] REG_FIFO_END = 10'h0A8;

   localparam logic [15:0] BIAS_RESET   = 16'h0200;
   localparam logic [11:0] PERIOD_RESET = 12'd380;
   localparam logic        CSR_IDX_PERIOD = 1'b0;

   // shared divider widths
   localparam int DVD_W = 13;
   localparam int DSR_W = 14;

   typedef struct packed {
      logic       load;
      logic       write;
      logic       pop;
      logic       sq_begin;
      logic       sq_end;
      logic       sq_chan;
      logic       acc_begin;
      logic       acc_end;
      logic       mix;
      logic       emit;
      logic [1:0] kind;
      logic       last;
   } hsu_cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       master_on;
      logic       div_busy;
      logic       rsp_full;
      logic [1:0] nsamp;
   } hsu_status_type;

   function automatic logic duty_bit(input logic [1:0] duty, input logic [2:0] step);
      logic [7:0] pat;
      case (duty)
         2'd0:    pat = 8'b1000_0000;
         2'd1:    pat = 8'b1000_0001;
         2'd2:    pat = 8'b1110_0001;
         default: pat = 8'b0111_1110;
      endcase
      return pat[step];
   endfunction

endpackage
`default_nettype wire

/* hdl/hsu_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsu_div
// Restoring divider, one quotient bit per cycle; shared by the square timers
// and the sample accumulator.
// ----------------------------------------------------------------------------
module hsu_div (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       start,
   input  wire  [hsu_pkg::DVD_W-1:0] dividend,
   input  wire  [hsu_pkg::DSR_W-1:0] divisor,
   output logic                      busy,
   output logic [hsu_pkg::DVD_W-1:0] quotient,
   output logic [hsu_pkg::DSR_W-1:0] remainder
);
   import hsu_pkg::*;

   localparam int CntW = $clog2(DVD_W);

   logic            busy_ff;
   logic [CntW-1:0] cnt_ff;
   logic [DVD_W-1:0] dvd_ff;
   logic [DVD_W-1:0] quo_ff;
   logic [DSR_W-1:0] dsr_ff;
   logic [DSR_W-1:0] rem_ff;
   logic [DSR_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CntW'(DVD_W - 1);
         dvd_ff  <= dividend;
         dsr_ff  <= divisor;
         rem_ff  <= '0;
         quo_ff  <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? DSR_W'(trial - {1'b0, dsr_ff}) : trial[DSR_W-1:0];
         quo_ff <= {quo_ff[DVD_W-2:0], fits};
         dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

/* hdl/hsu_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsu_datapath
// Sound registers, square channels, sample FIFOs, mixer and result register.
// ----------------------------------------------------------------------------
module hsu_datapath #(
   parameter int FIFO_DEPTH   = 32,
   parameter int REFILL_LEVEL = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire  hsu_pkg::hsu_cmd_type   cmd,
   output hsu_pkg::hsu_status_type      status,
   input  wire  [11:0]                  sample_period,
   input  wire  [2:0]                   req_operation,
   input  wire  [9:0]                   req_reg_offset,
   input  wire  [15:0]                  req_write_data,
   input  wire  [1:0]                   req_timer_index,
   input  wire  [9:0]                   req_cycles,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [1:0]                   rsp_kind,
   output logic signed [15:0]           rsp_left_sample,
   output logic signed [15:0]           rsp_right_sample,
   output logic [15:0]                  rsp_read_data,
   output logic                         rsp_dma_request_a,
   output logic                         rsp_dma_request_b,
   output logic                         rsp_last
);
   import hsu_pkg::*;

   localparam int AW = $clog2(FIFO_DEPTH);
   localparam int CW = $clog2(FIFO_DEPTH + 1);

   // latched request
   logic [2:0]  op_ff;
   logic [9:0]  off_ff;
   logic [15:0] data_ff;
   logic [1:0]  tsel_ff;
   logic [9:0]  cycles_ff;

   logic [10:0] sq_freq_ff [2];
   logic [1:0]  sq_duty_ff [2];
   logic [2:0]  sq_step_ff [2];
   logic [13:0] sq_timer_ff [2];
   logic        sq_on_ff [2];
   logic [3:0]  sq_vol_ff [2];
   logic [3:0]  sq_ivol_ff [2];
   logic [15:0] route_ff;
   logic [15:0] mix_ff;
   logic        master_ff;
   logic [15:0] bias_ff;
   logic [11:0] acc_ff;
   logic        pend_ff;
   logic [1:0]  nsamp_ff;

   logic [7:0]    mem_a [FIFO_DEPTH];
   logic [7:0]    mem_b [FIFO_DEPTH];
   logic [AW-1:0] head_ff [2];
   logic [AW-1:0] tail_ff [2];
   logic [CW-1:0] count_ff [2];
   logic [7:0]    held_ff [2];
   logic          dma_ff [2];

   logic signed [15:0] mix_left_ff;
   logic signed [15:0] mix_right_ff;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_kind_ff;
   logic [15:0] rsp_left_ff;
   logic [15:0] rsp_right_ff;
   logic [15:0] rsp_read_ff;
   logic        rsp_dma_a_ff;
   logic        rsp_dma_b_ff;
   logic        rsp_last_ff;

   // decode of the latched request
   logic        wr8;
   logic        hit_a;
   logic        hit_b;
   logic [9:0]  base;
   logic [15:0] rd_val;
   logic [15:0] wdata;
   logic        do_w16;
   logic        push_a;
   logic        push_b;
   logic        soft_reset;
   logic [13:0] sq_per [2];

   assign wr8   = op_ff == OP_WRITE8;
   assign hit_a = off_ff >= REG_SAMPLE_A && off_ff < REG_SAMPLE_B;
   assign hit_b = off_ff >= REG_SAMPLE_B && off_ff < REG_FIFO_END;
   assign base  = wr8 ? {off_ff[9:1], 1'b0} : off_ff;

   always_comb begin
      case (base)
         REG_ROUTE:  rd_val = route_ff;
         REG_MIX:    rd_val = mix_ff;
         REG_MASTER: rd_val = {8'd0, master_ff, 5'd0, sq_on_ff[1], sq_on_ff[0]};
         REG_BIAS:   rd_val = bias_ff;
         default:    rd_val = 16'd0;
      endcase
   end

   assign wdata  = !wr8 ? data_ff :
                   off_ff[0] ? {data_ff[7:0], rd_val[7:0]} : {rd_val[15:8], data_ff[7:0]};
   assign do_w16 = cmd.write && (op_ff == OP_WRITE16 || (wr8 && !hit_a && !hit_b));
   assign push_a = cmd.write && wr8 && hit_a && count_ff[0] != CW'(FIFO_DEPTH);
   assign push_b = cmd.write && wr8 && hit_b && count_ff[1] != CW'(FIFO_DEPTH);
   assign soft_reset = do_w16 && base == REG_MASTER && !wdata[7];

   always_comb begin
      for (int c = 0; c < 2; c++) begin
         sq_per[c] = {12'd2048 - {1'b0, sq_freq_ff[c]}, 2'b00};
      end
   end

   function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
      return (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // shared divider
   logic             div_start;
   logic [DVD_W-1:0] div_dvd;
   logic [DSR_W-1:0] div_dsr;
   logic             div_busy;
   logic [DVD_W-1:0] div_quo;
   logic [DSR_W-1:0] div_rem;
   logic             ch;
   logic             sq_short;

   assign ch       = cmd.sq_chan;
   assign sq_short = {4'd0, cycles_ff} < sq_timer_ff[ch];

   always_comb begin
      div_start = 1'b0;
      div_dvd   = DVD_W'(cycles_ff - 10'(sq_timer_ff[ch]));
      div_dsr   = sq_per[ch];
      if (cmd.sq_begin && sq_on_ff[ch] && !sq_short) begin
         div_start = 1'b1;
      end
      if (cmd.acc_begin) begin
         div_start = 1'b1;
         div_dvd   = DVD_W'(acc_ff) + DVD_W'(cycles_ff);
         div_dsr   = (sample_period == 12'd0) ? DSR_W'(1) : DSR_W'(sample_period);
      end
   end

   hsu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dsr),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // FIFO pop decisions
   logic          pop_match [2];
   logic          pop_do [2];
   logic [CW-1:0] count_after [2];

   always_comb begin
      for (int f = 0; f < 2; f++) begin
         pop_match[f]   = {1'b0, mix_ff[10 + 4*f]} == tsel_ff;
         pop_do[f]      = cmd.pop && pop_match[f] && count_ff[f] != '0;
         count_after[f] = pop_do[f] ? count_ff[f] - 1'b1 : count_ff[f];
      end
   end

   always_ff @(posedge clock) begin
      if (push_a) begin
         mem_a[tail_ff[0]] <= data_ff[7:0];
      end
      if (push_b) begin
         mem_b[tail_ff[1]] <= data_ff[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_operation;
         off_ff    <= req_reg_offset;
         data_ff   <= req_write_data;
         tsel_ff   <= req_timer_index;
         cycles_ff <= req_cycles;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || soft_reset) begin
         for (int c = 0; c < 2; c++) begin
            sq_freq_ff[c]  <= '0;
            sq_duty_ff[c]  <= '0;
            sq_step_ff[c]  <= '0;
            sq_timer_ff[c] <= '0;
            sq_on_ff[c]    <= 1'b0;
            sq_vol_ff[c]   <= '0;
            sq_ivol_ff[c]  <= '0;
            head_ff[c]     <= '0;
            tail_ff[c]     <= '0;
            count_ff[c]    <= '0;
            held_ff[c]     <= '0;
            dma_ff[c]      <= 1'b0;
         end
         route_ff  <= '0;
         mix_ff    <= '0;
         master_ff <= 1'b0;
         bias_ff   <= BIAS_RESET;
         acc_ff    <= '0;
         pend_ff   <= 1'b0;
         nsamp_ff  <= '0;
      end else begin
         if (do_w16) begin
            case (base)
               REG_SQ1_CTL, REG_SQ2_CTL: begin
                  sq_duty_ff[base[3]] <= wdata[7:6];
                  sq_ivol_ff[base[3]] <= wdata[15:12];
               end
               REG_SQ1_FREQ, REG_SQ2_FREQ: begin
                  sq_freq_ff[base[3]] <= wdata[10:0];
                  if (wdata[15]) begin
                     sq_on_ff[base[3]]    <= 1'b1;
                     sq_vol_ff[base[3]]   <= sq_ivol_ff[base[3]];
                     sq_timer_ff[base[3]] <= {12'd2048 - {1'b0, wdata[10:0]}, 2'b00};
                  end
               end
               REG_ROUTE: route_ff <= wdata;
               REG_MIX: begin
                  mix_ff <= wdata;
                  for (int f = 0; f < 2; f++) begin
                     if (wdata[11 + 4*f]) begin
                        head_ff[f]  <= '0;
                        tail_ff[f]  <= '0;
                        count_ff[f] <= '0;
                     end
                  end
               end
               REG_MASTER: master_ff <= 1'b1;
               REG_BIAS:   bias_ff <= wdata;
               default: ;
            endcase
         end
         if (push_a) begin
            tail_ff[0]  <= ptr_next(tail_ff[0]);
            count_ff[0] <= count_ff[0] + 1'b1;
         end
         if (push_b) begin
            tail_ff[1]  <= ptr_next(tail_ff[1]);
            count_ff[1] <= count_ff[1] + 1'b1;
         end
         if (cmd.pop) begin
            for (int f = 0; f < 2; f++) begin
               dma_ff[f] <= pop_match[f] && (32'(count_after[f]) <= 32'(REFILL_LEVEL));
               if (pop_do[f]) begin
                  head_ff[f]  <= ptr_next(head_ff[f]);
                  count_ff[f] <= count_after[f];
               end
            end
            if (pop_do[0]) held_ff[0] <= mem_a[head_ff[0]];
            if (pop_do[1]) held_ff[1] <= mem_b[head_ff[1]];
         end
         if (cmd.sq_begin) begin
            pend_ff <= div_start;
            if (sq_on_ff[ch] && sq_short) begin
               sq_timer_ff[ch] <= sq_timer_ff[ch] - {4'd0, cycles_ff};
            end
         end
         if (cmd.sq_end && pend_ff) begin
            sq_step_ff[ch]  <= sq_step_ff[ch] + div_quo[2:0] + 3'd1;
            sq_timer_ff[ch] <= sq_per[ch] - div_rem;
         end
         if (cmd.acc_end) begin
            acc_ff   <= div_rem[11:0];
            nsamp_ff <= (div_quo >= DVD_W'(3)) ? 2'd3 : div_quo[1:0];
         end
      end
   end

   // mixer
   logic signed [18:0] sum_l;
   logic signed [18:0] sum_r;
   logic signed [18:0] sq_term;
   logic signed [18:0] f_term;

   always_comb begin
      sum_l = '0;
      sum_r = '0;
      for (int c = 0; c < 2; c++) begin
         sq_term = signed'(19'({sq_vol_ff[c], 6'd0}));
         if (!duty_bit(sq_duty_ff[c], sq_step_ff[c])) sq_term = -sq_term;
         if (sq_on_ff[c] && route_ff[12 + c]) sum_l = sum_l + sq_term;
         if (sq_on_ff[c] && route_ff[8 + c])  sum_r = sum_r + sq_term;
      end
      for (int f = 0; f < 2; f++) begin
         f_term = mix_ff[2 + f] ? signed'({{2{held_ff[f][7]}}, held_ff[f], 9'd0})
                                : signed'({{3{held_ff[f][7]}}, held_ff[f], 8'd0});
         if (mix_ff[9 + 4*f]) sum_l = sum_l + f_term;
         if (mix_ff[8 + 4*f]) sum_r = sum_r + f_term;
      end
   end

   function automatic logic [15:0] clamp16(input logic signed [18:0] x);
      if (x > 19'sd32767)  return 16'h7FFF;
      if (x < -19'sd32768) return 16'h8000;
      return x[15:0];
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.mix) begin
         mix_left_ff  <= signed'(clamp16(sum_l));
         mix_right_ff <= signed'(clamp16(sum_r));
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_kind_ff  <= cmd.kind;
         rsp_last_ff  <= cmd.last;
         rsp_left_ff  <= (cmd.kind == KIND_SAMPLE) ? mix_left_ff : 16'd0;
         rsp_right_ff <= (cmd.kind == KIND_SAMPLE) ? mix_right_ff : 16'd0;
         rsp_read_ff  <= (cmd.kind == KIND_READ) ? rd_val : 16'd0;
         rsp_dma_a_ff <= (cmd.kind == KIND_DMA) && dma_ff[0];
         rsp_dma_b_ff <= (cmd.kind == KIND_DMA) && dma_ff[1];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_left_sample   = signed'(rsp_left_ff);
   assign rsp_right_sample  = signed'(rsp_right_ff);
   assign rsp_read_data     = rsp_read_ff;
   assign rsp_dma_request_a = rsp_dma_a_ff;
   assign rsp_dma_request_b = rsp_dma_b_ff;
   assign rsp_last          = rsp_last_ff;

   assign status.op        = op_ff;
   assign status.master_on = master_ff;
   assign status.div_busy  = div_busy;
   assign status.rsp_full  = rsp_valid_ff;
   assign status.nsamp     = nsamp_ff;

endmodule
`default_nettype wire

/* hdl/hsu_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsu_ctrl
// Sequencer: decodes each request and steps the datapath through it.
// ----------------------------------------------------------------------------
module hsu_ctrl (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire  hsu_pkg::hsu_status_type status,
   output hsu_pkg::hsu_cmd_type         cmd
);
   import hsu_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_WRITE, S_POP, S_EMIT_ONE, S_SQ_GO, S_SQ_WAIT,
      S_ACC_GO, S_ACC_WAIT, S_MIX, S_EMIT_MIX
   } state_type;

   state_type  state_ff;
   logic [1:0] kind_ff;
   logic       chan_ff;
   logic [1:0] count_ff;
   logic       mix_last;

   assign mix_last  = (count_ff + 2'd1) == status.nsamp;
   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      cmd         = '0;
      cmd.sq_chan = chan_ff;
      cmd.kind    = kind_ff;
      case (state_ff)
         S_IDLE:     cmd.load = req_valid;
         S_WRITE:    cmd.write = 1'b1;
         S_POP:      cmd.pop = 1'b1;
         S_EMIT_ONE: begin
            cmd.emit = !status.rsp_full;
            cmd.last = 1'b1;
         end
         S_SQ_GO:    cmd.sq_begin = 1'b1;
         S_SQ_WAIT:  cmd.sq_end = !status.div_busy;
         S_ACC_GO:   cmd.acc_begin = 1'b1;
         S_ACC_WAIT: cmd.acc_end = !status.div_busy;
         S_MIX:      cmd.mix = 1'b1;
         S_EMIT_MIX: begin
            cmd.emit = !status.rsp_full;
            cmd.kind = KIND_SAMPLE;
            cmd.last = mix_last;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= KIND_SAMPLE;
         chan_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) state_ff <= S_DECODE;
            end
            S_DECODE: begin
               chan_ff  <= 1'b0;
               count_ff <= '0;
               case (status.op)
                  OP_WRITE16, OP_WRITE8: state_ff <= S_WRITE;
                  OP_READ16: begin
                     kind_ff  <= KIND_READ;
                     state_ff <= S_EMIT_ONE;
                  end
                  OP_TIMER: begin
                     kind_ff  <= KIND_DMA;
                     state_ff <= S_POP;
                  end
                  OP_TICK: state_ff <= status.master_on ? S_SQ_GO : S_IDLE;
                  default: state_ff <= S_IDLE;
               endcase
            end
            S_WRITE:    state_ff <= S_IDLE;
            S_POP:      state_ff <= S_EMIT_ONE;
            S_EMIT_ONE: begin
               if (!status.rsp_full) state_ff <= S_IDLE;
            end
            S_SQ_GO:    state_ff <= S_SQ_WAIT;
            S_SQ_WAIT: begin
               if (!status.div_busy) begin
                  chan_ff  <= 1'b1;
                  state_ff <= chan_ff ? S_ACC_GO : S_SQ_GO;
               end
            end
            S_ACC_GO:   state_ff <= S_ACC_WAIT;
            S_ACC_WAIT: begin
               if (!status.div_busy) state_ff <= S_MIX;
            end
            S_MIX:      state_ff <= (status.nsamp == 2'd0) ? S_IDLE : S_EMIT_MIX;
            S_EMIT_MIX: begin
               if (!status.rsp_full) begin
                  count_ff <= count_ff + 2'd1;
                  if (mix_last) state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

/* hdl/handheld_sound_unit_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// handheld_sound_unit_core
// Sound unit: two square channels, two sample FIFOs and a stereo mixer behind
// a register window; sample period set through the configuration port.
// ----------------------------------------------------------------------------
// Ticks with master enable on run the shared restoring divider for each square
// timer whose channel is on and whose count the tick reaches, then for the
// sample accumulator, then emit each stereo sample. One request is in flight
// at a time. Reset (synchronous, active high) clears the sound registers,
// controller and result valid flag; sample period to 380.
// FIFO storage is not cleared; only its pointers are.
module handheld_sound_unit_core #(
   parameter int FIFO_DEPTH   = 32,
   parameter int REFILL_LEVEL = 16
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire  [2:0]         req_operation,
   input  wire  [9:0]         req_reg_offset,
   input  wire  [15:0]        req_write_data,
   input  wire  [1:0]         req_timer_index,
   input  wire  [9:0]         req_cycles,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic [1:0]         rsp_kind,
   output logic signed [15:0] rsp_left_sample,
   output logic signed [15:0] rsp_right_sample,
   output logic [15:0]        rsp_read_data,
   output logic               rsp_dma_request_a,
   output logic               rsp_dma_request_b,
   output logic               rsp_last,
   input  wire                psel,
   input  wire                penable,
   input  wire                pwrite,
   input  wire  [2:0]         paddr,
   input  wire  [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import hsu_pkg::*;

   logic [11:0]    period_ff;
   hsu_cmd_type    cmd;
   hsu_status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else if (psel && penable && pwrite && paddr[2] == CSR_IDX_PERIOD) begin
         period_ff <= pwdata[11:0];
      end
   end

   assign prdata = (paddr[2] == CSR_IDX_PERIOD) ? {20'd0, period_ff} : 32'd0;
   assign pready = 1'b1;

   hsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   hsu_datapath #(
      .FIFO_DEPTH   (FIFO_DEPTH),
      .REFILL_LEVEL (REFILL_LEVEL)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .sample_period     (period_ff),
      .req_operation     (req_operation),
      .req_reg_offset    (req_reg_offset),
      .req_write_data    (req_write_data),
      .req_timer_index   (req_timer_index),
      .req_cycles        (req_cycles),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_left_sample   (rsp_left_sample),
      .rsp_right_sample  (rsp_right_sample),
      .rsp_read_data     (rsp_read_data),
      .rsp_dma_request_a (rsp_dma_request_a),
      .rsp_dma_request_b (rsp_dma_request_b),
      .rsp_last          (rsp_last)
   );

endmodule
`default_nettype wire

/* hdl/hsu_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsu_checker
// Port-level checks on the sound unit, bound to the top level.
// ----------------------------------------------------------------------------
module hsu_checker (
   input wire               clock,
   input wire               reset,
   input wire               req_valid,
   input wire               req_ready,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input wire [1:0]         rsp_kind,
   input wire signed [15:0] rsp_left_sample,
   input wire signed [15:0] rsp_right_sample,
   input wire [15:0]        rsp_read_data,
   input wire               rsp_last
);
   import hsu_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // one request in flight
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_read_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_READ || rsp_kind == KIND_DMA) |-> rsp_last)
      else $error("single result not marked last");

   a_clean_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_SAMPLE |->
         rsp_left_sample == 16'sd0 && rsp_right_sample == 16'sd0)
      else $error("sample fields set on non-sample result");

   a_sample_nodata: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_SAMPLE |-> rsp_read_data == 16'd0)
      else $error("read data set on sample result");

endmodule

bind handheld_sound_unit_core hsu_checker u_hsu_checker (.*);
`default_nettype wire

/* verif/hsu_checker.sv */
// ----------------------------------------------------------------------------
// hsu_scoreboard
// Watches the request, response and APB channels of the sound unit, keeps its
// own copy of the unit's state, predicts every response and compares them.
// ----------------------------------------------------------------------------
module hsu_scoreboard (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   input  wire               req_ready,
   input  wire        [2:0]  req_operation,
   input  wire        [9:0]  req_reg_offset,
   input  wire        [15:0] req_write_data,
   input  wire        [1:0]  req_timer_index,
   input  wire        [9:0]  req_cycles,
   input  wire               rsp_valid,
   input  wire               rsp_ready,
   input  wire        [1:0]  rsp_kind,
   input  wire signed [15:0] rsp_left_sample,
   input  wire signed [15:0] rsp_right_sample,
   input  wire        [15:0] rsp_read_data,
   input  wire               rsp_dma_request_a,
   input  wire               rsp_dma_request_b,
   input  wire               rsp_last,
   input  wire               psel,
   input  wire               penable,
   input  wire               pwrite,
   input  wire        [2:0]  paddr,
   input  wire        [31:0] pwdata,
   input  wire               pready,
   output int                fail_count,
   output int                pending
);
   import hsu_pkg::*;

   localparam int FIFO_SLOTS   = 32;
   localparam int REFILL_MARK  = 16;
   localparam int MAX_PER_TICK = 3;
   localparam logic [2:0] PERIOD_ADDR = {CSR_IDX_PERIOD, 2'b00};
   // duty waveforms, bit n is step n
   localparam logic [7:0] DUTY_WAVE [4] =
      '{8'b1000_0000, 8'b1000_0001, 8'b1110_0001, 8'b0111_1110};

   typedef struct packed {
      logic [1:0]        kind;
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic [15:0]       rdata;
      logic              dma_a;
      logic              dma_b;
      logic              last;
   } sound_result_type;

   sound_result_type mix_results_q[$];

   logic [11:0] sample_period;
   logic [10:0] sq_freq [2];
   logic [1:0]  sq_duty [2];
   logic [2:0]  sq_step [2];
   int          sq_timer [2];
   logic        sq_on [2];
   logic [3:0]  sq_vol [2];
   logic [3:0]  sq_init_vol [2];
   logic [15:0] route_ctl, mix_ctl, bias;
   logic        master;
   int          accum;
   logic [7:0]  fifo_data [2][FIFO_SLOTS];
   int          rd_ptr [2], wr_ptr [2], fifo_fill [2];
   logic [7:0]  held [2];

   function automatic void clear_fifo(input int f);
      rd_ptr[f] = 0;
      wr_ptr[f] = 0;
      fifo_fill[f] = 0;
   endfunction

   function automatic void clear_sound();
      for (int c = 0; c < 2; c++) begin
         sq_freq[c] = '0; sq_duty[c] = '0; sq_step[c] = '0; sq_timer[c] = 0;
         sq_on[c] = 1'b0; sq_vol[c] = '0; sq_init_vol[c] = '0; held[c] = '0;
         clear_fifo(c);
      end
      route_ctl = '0;
      mix_ctl = '0;
      master = 1'b0;
      bias = BIAS_RESET;
      accum = 0;
   endfunction

   function automatic int square_period(input int c);
      return (2048 - int'(sq_freq[c])) * 4;
   endfunction

   function automatic void write_word(input logic [9:0] off, input logic [15:0] v);
      case (off)
         REG_SQ1_CTL, REG_SQ2_CTL: begin
            sq_duty[off == REG_SQ2_CTL] = v[7:6];
            sq_init_vol[off == REG_SQ2_CTL] = v[15:12];
         end
         REG_SQ1_FREQ, REG_SQ2_FREQ: begin
            int c;
            c = (off == REG_SQ2_FREQ);
            sq_freq[c] = v[10:0];
            if (v[15]) begin
               sq_on[c] = 1'b1;
               sq_vol[c] = sq_init_vol[c];
               sq_timer[c] = square_period(c);
            end
         end
         REG_ROUTE: route_ctl = v;
         REG_MIX: begin
            mix_ctl = v;
            if (v[11]) clear_fifo(0);
            if (v[15]) clear_fifo(1);
         end
         REG_MASTER: begin
            if (v[7]) master = 1'b1;
            else clear_sound();
         end
         REG_BIAS: bias = v;
         default: ;
      endcase
   endfunction

   function automatic logic [15:0] read_word(input logic [9:0] off);
      case (off)
         REG_ROUTE:  return route_ctl;
         REG_MIX:    return mix_ctl;
         REG_MASTER: return {8'd0, master, 5'd0, sq_on[1], sq_on[0]};
         REG_BIAS:   return bias;
         default:    return 16'd0;
      endcase
   endfunction

   function automatic void advance_square(input int c, input int cyc);
      int rem;
      rem = cyc;
      if (!sq_on[c]) return;
      while (rem >= sq_timer[c]) begin
         rem -= sq_timer[c];
         sq_step[c] = sq_step[c] + 3'd1;
         sq_timer[c] = square_period(c);
      end
      sq_timer[c] -= rem;
   endfunction

   function automatic logic signed [15:0] saturate(input int x);
      if (x > 32767) return 16'sh7FFF;
      if (x < -32768) return 16'sh8000;
      return x[15:0];
   endfunction

   function automatic void stereo_mix(output logic signed [15:0] l,
                                      output logic signed [15:0] r);
      int left, right, s;
      left = 0;
      right = 0;
      for (int c = 0; c < 2; c++) begin
         if (sq_on[c]) begin
            s = DUTY_WAVE[sq_duty[c]][sq_step[c]] ? int'(sq_vol[c]) : -int'(sq_vol[c]);
            if (route_ctl[12 + c]) left += s * 64;
            if (route_ctl[8 + c]) right += s * 64;
         end
      end
      for (int f = 0; f < 2; f++) begin
         s = int'($signed(held[f]));
         s *= mix_ctl[2 + f] ? 512 : 256;
         if (mix_ctl[9 + 4 * f]) left += s;
         if (mix_ctl[8 + 4 * f]) right += s;
      end
      l = saturate(left);
      r = saturate(right);
   endfunction

   function automatic void predict_sound(input logic [2:0] op, input logic [9:0] off,
                                         input logic [15:0] data, input logic [1:0] tsel,
                                         input logic [9:0] cyc);
      sound_result_type res;
      logic [15:0] cur;
      int per, n, f;
      res = '0;
      case (op)
         OP_WRITE16: write_word(off, data);
         OP_WRITE8: begin
            if (off >= REG_SAMPLE_A && off < REG_FIFO_END) begin
               f = (off >= REG_SAMPLE_B);
               if (fifo_fill[f] < FIFO_SLOTS) begin
                  fifo_data[f][wr_ptr[f]] = data[7:0];
                  wr_ptr[f] = (wr_ptr[f] + 1) % FIFO_SLOTS;
                  fifo_fill[f]++;
               end
            end else begin
               cur = read_word({off[9:1], 1'b0});
               write_word({off[9:1], 1'b0},
                          off[0] ? {data[7:0], cur[7:0]} : {cur[15:8], data[7:0]});
            end
         end
         OP_READ16: begin
            res.kind = KIND_READ;
            res.rdata = read_word(off);
            res.last = 1'b1;
            mix_results_q.push_back(res);
         end
         OP_TIMER: begin
            res.kind = KIND_DMA;
            res.last = 1'b1;
            for (f = 0; f < 2; f++) begin
               if ({1'b0, mix_ctl[10 + 4 * f]} == tsel) begin
                  if (fifo_fill[f] > 0) begin
                     held[f] = fifo_data[f][rd_ptr[f]];
                     rd_ptr[f] = (rd_ptr[f] + 1) % FIFO_SLOTS;
                     fifo_fill[f]--;
                  end
                  if (fifo_fill[f] <= REFILL_MARK) begin
                     if (f == 0) res.dma_a = 1'b1;
                     else res.dma_b = 1'b1;
                  end
               end
            end
            mix_results_q.push_back(res);
         end
         OP_TICK: if (master) begin
            per = (sample_period == 0) ? 1 : int'(sample_period);
            advance_square(0, int'(cyc));
            advance_square(1, int'(cyc));
            accum += int'(cyc);
            n = 0;
            while (accum >= per && n < MAX_PER_TICK) begin
               accum -= per;
               res = '0;
               res.kind = KIND_SAMPLE;
               stereo_mix(res.left, res.right);
               mix_results_q.push_back(res);
               n++;
            end
            accum = accum % per;
            if (n > 0) mix_results_q[$].last = 1'b1;
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      sound_result_type got, want;
      if (reset) begin
         clear_sound();
         sample_period = PERIOD_RESET;
         mix_results_q.delete();
         fail_count = 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == PERIOD_ADDR)
            sample_period = pwdata[11:0];
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_kind, rsp_left_sample, rsp_right_sample, rsp_read_data,
                    rsp_dma_request_a, rsp_dma_request_b, rsp_last};
            if (mix_results_q.size() == 0) begin
               $display("%0t: unexpected response kind=%0d l=%0d r=%0d rd=%h",
                        $time, got.kind, got.left, got.right, got.rdata);
               fail_count++;
            end else begin
               want = mix_results_q.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch exp kind=%0d l=%0d r=%0d rd=%h dma=%b%b last=%b",
                           $time, want.kind, want.left, want.right, want.rdata,
                           want.dma_a, want.dma_b, want.last);
                  $display("%0t:          got kind=%0d l=%0d r=%0d rd=%h dma=%b%b last=%b",
                           $time, got.kind, got.left, got.right, got.rdata,
                           got.dma_a, got.dma_b, got.last);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            predict_sound(req_operation, req_reg_offset, req_write_data,
                          req_timer_index, req_cycles);
      end
      pending = mix_results_q.size();
   end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives the sound unit with directed and random register traffic, FIFO
// bytes, timer events and ticks over several sample periods; a checker beside
// the unit predicts and compares every response.
// ----------------------------------------------------------------------------
module tb;
   import hsu_pkg::*;

   localparam logic [2:0] PERIOD_ADDR = {CSR_IDX_PERIOD, 2'b00};
   localparam int SETTLE_CYCLES = 80;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   wire                req_ready;
   logic [2:0]         req_operation = OP_READ16;
   logic [9:0]         req_reg_offset = '0;
   logic [15:0]        req_write_data = '0;
   logic [1:0]         req_timer_index = '0;
   logic [9:0]         req_cycles = '0;
   wire                rsp_valid;
   logic               rsp_ready = 1'b0;
   wire  [1:0]         rsp_kind;
   wire signed [15:0]  rsp_left_sample, rsp_right_sample;
   wire  [15:0]        rsp_read_data;
   wire                rsp_dma_request_a, rsp_dma_request_b, rsp_last;
   logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   wire  [31:0]        prdata;
   wire                pready;
   int                 fail_count, pending;

   handheld_sound_unit_core uut (.*);
   hsu_scoreboard checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: stall mode reshuffled whenever its down-counter runs out
   int ready_mode = 0, ready_cnt = 0;
   always @(negedge clock) begin
      if (ready_cnt == 0) begin
         ready_mode <= int'($urandom_range(0, 3));
         ready_cnt <= 150;
      end else begin
         ready_cnt <= ready_cnt - 1;
      end
      case (ready_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= ready_cnt[1];
      endcase
   end

   task automatic send(input logic [2:0] op, input logic [9:0] off,
                       input logic [15:0] data, input logic [1:0] tsel,
                       input logic [9:0] cyc);
      @(negedge clock);
      req_valid <= 1'b1;
      req_operation <= op;
      req_reg_offset <= off;
      req_write_data <= data;
      req_timer_index <= tsel;
      req_cycles <= cyc;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic pause(input int n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // hold off until every outstanding response is back and the unit is quiet
   task automatic drain();
      pause(0);
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_period(input logic [11:0] value);
      @(negedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= PERIOD_ADDR; pwdata <= {20'd0, value};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   task automatic random_request();
      logic [9:0] mapped [8] = '{REG_SQ1_CTL, REG_SQ1_FREQ, REG_SQ2_CTL, REG_SQ2_FREQ,
                                 REG_ROUTE, REG_MIX, REG_MASTER, REG_BIAS};
      logic [9:0]  off;
      logic [15:0] data;
      int r;
      r = $urandom_range(0, 99);
      off = mapped[$urandom_range(0, 7)];
      data = 16'($urandom);
      if (r < 30)
         send(OP_TICK, '0, '0, '0,
              10'($urandom_range(0, 1) ? $urandom_range(0, 60) : $urandom_range(0, 1023)));
      else if (r < 50)
         send(OP_WRITE8, 10'(REG_SAMPLE_A + $urandom_range(0, 7)), data, '0, '0);
      else if (r < 62)
         send(OP_TIMER, '0, '0, 2'(($urandom_range(0, 7) == 0) ? $urandom_range(2, 3)
                                                               : $urandom_range(0, 1)), '0);
      else if (r < 72)
         send(OP_READ16, $urandom_range(0, 1) ? off : 10'($urandom), '0, '0, '0);
      else if (r < 90) begin
         // keep the unit enabled most of the time so that ticks produce samples
         if (off == REG_MASTER && $urandom_range(0, 9) != 0) data[7] = 1'b1;
         if (off == REG_SQ1_FREQ || off == REG_SQ2_FREQ) data[15] = $urandom_range(0, 3) != 0;
         if (off == REG_MIX && $urandom_range(0, 3) != 0) {data[15], data[11]} = 2'b00;
         send(OP_WRITE16, off, data, '0, '0);
      end else if (r < 95)
         send(OP_WRITE8, 10'($urandom), data, '0, '0);
      else
         send(OP_WRITE16, 10'($urandom), data, '0, '0);
   endtask

   task automatic enable_sound();
      send(OP_WRITE16, REG_MASTER, 16'h0080, '0, '0);
      send(OP_WRITE16, REG_SQ1_CTL, 16'($urandom), '0, '0);
      send(OP_WRITE16, REG_SQ1_FREQ, 16'h8000 | 16'($urandom_range(0, 2047)), '0, '0);
      send(OP_WRITE16, REG_SQ2_CTL, 16'($urandom), '0, '0);
      send(OP_WRITE16, REG_SQ2_FREQ, 16'h8000 | 16'($urandom_range(0, 2047)), '0, '0);
      send(OP_WRITE16, REG_ROUTE, 16'($urandom), '0, '0);
      send(OP_WRITE16, REG_MIX, 16'($urandom) & 16'h77FF, '0, '0);
   endtask

   initial begin
      logic [11:0] periods [6] = '{12'd4095, 12'd1, 12'd0, 12'd380, 12'd37, 12'd0};
      int burst;
      periods[5] = 12'($urandom_range(1, 4095));
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed
      set_period(12'd200);
      send(OP_READ16, REG_ROUTE, '0, '0, '0);
      send(OP_READ16, REG_MIX, '0, '0, '0);
      send(OP_READ16, REG_MASTER, '0, '0, '0);
      send(OP_READ16, REG_BIAS, '0, '0, '0);
      send(OP_READ16, 10'h3FF, '0, '0, '0);
      send(OP_READ16, REG_BIAS + 10'd1, '0, '0, '0);
      send(OP_WRITE8, REG_BIAS + 10'd1, 16'hFFAB, '0, '0);
      send(OP_READ16, REG_BIAS, '0, '0, '0);
      send(OP_WRITE16, REG_MASTER, 16'h0080, '0, '0);
      send(OP_WRITE16, REG_SQ1_CTL, 16'hF0C0, '0, '0);
      send(OP_WRITE16, REG_SQ2_CTL, 16'h8040, '0, '0);
      send(OP_WRITE16, REG_SQ1_FREQ, 16'h87FF, '0, '0);
      send(OP_WRITE16, REG_SQ2_FREQ, 16'h8000, '0, '0);
      send(OP_WRITE16, REG_ROUTE, 16'hFFFF, '0, '0);
      send(OP_WRITE16, REG_MIX, 16'h730C, '0, '0);
      send(OP_WRITE16, REG_SAMPLE_A, 16'h1234, '0, '0);
      send(OP_WRITE8, REG_SAMPLE_A, 16'h007F, '0, '0);
      send(OP_WRITE8, REG_SAMPLE_A + 10'd3, 16'h0080, '0, '0);
      send(OP_WRITE8, REG_SAMPLE_B + 10'd2, 16'h0001, '0, '0);
      send(OP_TIMER, '0, '0, 2'd0, '0);
      send(OP_TIMER, '0, '0, 2'd1, '0);
      send(OP_TIMER, '0, '0, 2'd3, '0);
      send(OP_TICK, '0, '0, '0, 10'h3FF);
      send(OP_READ16, REG_MASTER, '0, '0, '0);
      send(OP_WRITE8, REG_MASTER, 16'h0000, '0, '0);
      send(OP_TICK, '0, '0, '0, 10'd500);

      // random phases, one sample period each
      foreach (periods[p]) begin
         drain();
         set_period(periods[p]);
         enable_sound();
         burst = 0;
         for (int i = 0; i < 34; i++) begin
            if (burst == 0) begin
               burst = $urandom_range(1, 12);
               if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 10));
            end
            random_request();
            burst--;
         end
      end

      drain();
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #5000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

/* filelist.f */
hdl/hsu_pkg.sv
hdl/hsu_div.sv
hdl/hsu_datapath.sv
hdl/hsu_ctrl.sv
hdl/handheld_sound_unit_core.sv
hdl/hsu_checker.sv
verif/hsu_checker.sv
verif/tb.sv
